// ===== rtl/tpdm_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt PID motor mixer.
// No dependencies; every other file in rtl/ except tpdm_checker imports this package.
`timescale 1ns / 1ps
package tpdm_pkg;

  localparam int CORDIC_STEPS   = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int SUM_FRAC_BITS  = GAIN_FRAC_BITS + 7;
  localparam int NUM_STEPS      = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  localparam int GAIN_W  = 24;
  localparam int ANG_W   = 16;
  localparam int ERR_W   = 17;
  localparam int PWM_W   = 11;
  localparam int INTEG_W = 40;
  localparam int MULA_W  = 51;
  localparam int PROD_W  = 64;
  localparam int DIVN_W  = 50;
  localparam int DIVD_W  = 16;
  localparam int CX_W    = 19;
  localparam int CACC_W  = 25;

  localparam int ANG_HALF    = 23040;
  localparam int ANG_QUARTER = 11520;
  localparam logic [23:0] DERIV_SCALE = 24'd1000;

  localparam logic [23:0] GAIN_PROP_RST = 24'd6554;
  localparam logic [10:0] THROTTLE_RST  = 11'd1100;
  localparam logic [10:0] PWM_MIN       = 11'd1000;
  localparam logic [10:0] PWM_MAX       = 11'd2000;

  typedef enum logic [2:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_THROTTLE   = 3'd3,
    REG_TARGET     = 3'd4
  } reg_idx_t;

  // atan(2^-i) in 1/32768 degree.
  function automatic logic signed [CACC_W-1:0] atan_of(input logic [4:0] i);
    logic signed [CACC_W-1:0] v;
    case (i)
      5'd0:  v = 25'sd1474560;
      5'd1:  v = 25'sd870484;
      5'd2:  v = 25'sd459940;
      5'd3:  v = 25'sd233473;
      5'd4:  v = 25'sd117189;
      5'd5:  v = 25'sd58652;
      5'd6:  v = 25'sd29333;
      5'd7:  v = 25'sd14667;
      5'd8:  v = 25'sd7334;
      5'd9:  v = 25'sd3667;
      5'd10: v = 25'sd1833;
      5'd11: v = 25'sd917;
      5'd12: v = 25'sd458;
      5'd13: v = 25'sd229;
      5'd14: v = 25'sd115;
      5'd15: v = 25'sd57;
      5'd16: v = 25'sd29;
      5'd17: v = 25'sd14;
      5'd18: v = 25'sd7;
      5'd19: v = 25'sd4;
      5'd20: v = 25'sd2;
      5'd21: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tilt_pid_differential_motor_mix_core.sv =====
// Top level of the tilt PID controller with differential motor mix.
// Depends on tpdm_pkg, tpdm_cordic, tpdm_mul and tpdm_div.
`timescale 1ns / 1ps
// Each accepted sample (accel_x, accel_z, elapsed_ms) yields one result: the tilt
// angle atan2(x, z) in 1/128 degree, its error against target_angle, the clamped
// PID drive and the two motor pulse widths. The steps run in order: the 16
// CORDIC steps with their start and finish, the error, four 24-bit serial
// multiplies (P, I, D and the x1000 rate scale), the 50-bit serial divide that is
// skipped when elapsed_ms is zero, and the sum and the output load. No new sample
// is taken until the result is loaded; a result that is still waiting in the output
// register delays the load for as long as it waits. Register writes go
// through the cfg channel, which is ready only while no sample is in flight;
// writing gain_integ also clears the integral.
module tilt_pid_differential_motor_mix_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x[15:0], accel_z[31:16], elapsed_ms[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  // pwm_left[10:0], pwm_right[21:11], drive[32:22], tilt_angle[48:33],
  // angle_error[65:49], zero fill above
  output logic [71:0] out_tdata,
  output logic [0:0]  out_tuser,  // zero_interval[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import tpdm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CORD = 10'b0000000010,
    S_ERR  = 10'b0000000100,
    S_MP   = 10'b0000001000,
    S_MI   = 10'b0000010000,
    S_MD   = 10'b0000100000,
    S_MK   = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_SUM  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  localparam logic signed [63:0] I_LIM   = 64'sd1 <<< 35;
  localparam logic signed [63:0] SUM_LIM = 64'sd1000 <<< SUM_FRAC_BITS;
  localparam logic [63:0] ACC_MAX = (64'd1 << (INTEG_W - 1)) - 64'd1;
  localparam logic [63:0] ACC_NEG = 64'd1 << (INTEG_W - 1);

  state_t state_r;

  logic signed [GAIN_W-1:0]  gp_r, gi_r, gd_r;
  logic [PWM_W-1:0]          thr_r;
  logic signed [ANG_W-1:0]   tgt_r;

  logic signed [15:0]        ax_r, az_r;
  logic [15:0]               dt_r;
  logic signed [ANG_W-1:0]   ang_r;
  logic signed [ERR_W-1:0]   err_r, last_err_r;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [63:0]        p_r, d_r, sum_r;

  logic                      cord_go_r, mul_go_r, div_go_r;
  logic [MULA_W-1:0]         op_a_r;
  logic [GAIN_W-1:0]         op_b_r;
  logic                      cord_done, mul_done, div_done;
  logic signed [ANG_W-1:0]   cord_ang;
  logic [PROD_W-1:0]         mul_prod;
  logic [DIVN_W-1:0]         div_q;

  logic                      out_valid_r;
  logic [71:0]               out_data_r;
  logic                      out_zero_r;

  logic signed [ERR_W-1:0]   err_c;
  logic signed [INTEG_W:0]   isum;
  logic signed [ERR_W:0]     diff;
  logic [PROD_W-1:0]         sh;
  logic signed [63:0]        icl, sum_c, sc, smag, dmag;
  logic signed [PWM_W-1:0]   drv;
  logic signed [12:0]        thr13, pl13, pr13;
  logic [PWM_W-1:0]          pl, pr;

  tpdm_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_go_r),
    .accel_x(ax_r), .accel_z(az_r), .done(cord_done), .angle(cord_ang)
  );

  tpdm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go_r),
    .op_a(op_a_r), .op_b(op_b_r), .done(mul_done), .prod(mul_prod)
  );

  tpdm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r),
    .dividend(mul_prod[DIVN_W-1:0]), .divisor(dt_r), .done(div_done), .quotient(div_q)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  assign err_c = ERR_W'(ang_r) - ERR_W'(tgt_r);
  assign isum  = (INTEG_W + 1)'(integ_r) + (INTEG_W + 1)'(err_r);
  assign diff  = (ERR_W + 1)'(err_r) - (ERR_W + 1)'(last_err_r);
  assign sh    = mul_prod >> GAIN_FRAC_BITS;

  // Integral update: the product magnitude is truncated, then signed and saturated.
  always_comb begin
    if (!(gi_r[GAIN_W-1] ^ isum[INTEG_W])) begin
      integ_nxt = (sh > ACC_MAX) ? INTEG_W'(ACC_MAX) : INTEG_W'(sh);
    end else begin
      integ_nxt = (sh > ACC_NEG) ? INTEG_W'(ACC_NEG) : INTEG_W'(~sh + 64'd1);
    end
  end

  always_comb begin
    if (64'(integ_r) > I_LIM)       icl = I_LIM;
    else if (64'(integ_r) < -I_LIM) icl = -I_LIM;
    else                            icl = 64'(integ_r);
    sum_c = p_r + (icl <<< GAIN_FRAC_BITS) + d_r;

    if (sum_r > SUM_LIM)       sc = SUM_LIM;
    else if (sum_r < -SUM_LIM) sc = -SUM_LIM;
    else                       sc = sum_r;
    smag = (sc < 0) ? -sc : sc;
    dmag = smag >>> SUM_FRAC_BITS;
    drv  = (sc < 0) ? -PWM_W'(dmag) : PWM_W'(dmag);

    thr13 = signed'({2'b00, thr_r});
    pl13  = thr13 + 13'(drv);
    pr13  = thr13 - 13'(drv);
    if (pl13 < signed'({2'b00, PWM_MIN}))      pl = PWM_MIN;
    else if (pl13 > signed'({2'b00, PWM_MAX})) pl = PWM_MAX;
    else                                       pl = pl13[PWM_W-1:0];
    if (pr13 < signed'({2'b00, PWM_MIN}))      pr = PWM_MIN;
    else if (pr13 > signed'({2'b00, PWM_MAX})) pr = PWM_MAX;
    else                                       pr = pr13[PWM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cord_go_r   <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      gp_r        <= signed'(GAIN_PROP_RST);
      gi_r        <= '0;
      gd_r        <= '0;
      thr_r       <= THROTTLE_RST;
      tgt_r       <= '0;
      integ_r     <= '0;
      last_err_r  <= '0;
    end else begin
      cord_go_r <= 1'b0;
      mul_go_r  <= 1'b0;
      div_go_r  <= 1'b0;
      // In S_FIN the load below decides the valid flag on its own.
      if (out_valid_r && out_tready && state_r != S_FIN) out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_PROP:  gp_r <= signed'(cfg_data);
          REG_GAIN_INTEG: begin
            gi_r    <= signed'(cfg_data);
            integ_r <= '0;
          end
          REG_GAIN_DERIV: gd_r <= signed'(cfg_data);
          REG_THROTTLE:   thr_r <= cfg_data[PWM_W-1:0];
          REG_TARGET:     tgt_r <= signed'(cfg_data[ANG_W-1:0]);
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ax_r      <= signed'(in_tdata[15:0]);
            az_r      <= signed'(in_tdata[31:16]);
            dt_r      <= in_tdata[47:32];
            cord_go_r <= 1'b1;
            state_r   <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            ang_r   <= cord_ang;
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          err_r    <= err_c;
          op_a_r   <= MULA_W'(err_c[ERR_W-1] ? -err_c : err_c);
          op_b_r   <= gp_r[GAIN_W-1] ? GAIN_W'(-gp_r) : GAIN_W'(gp_r);
          mul_go_r <= 1'b1;
          state_r  <= S_MP;
        end
        S_MP: begin
          if (mul_done) begin
            p_r      <= (gp_r[GAIN_W-1] ^ err_r[ERR_W-1]) ? -signed'(mul_prod)
                                                           : signed'(mul_prod);
            op_a_r   <= MULA_W'(isum[INTEG_W] ? -isum : isum);
            op_b_r   <= gi_r[GAIN_W-1] ? GAIN_W'(-gi_r) : GAIN_W'(gi_r);
            mul_go_r <= 1'b1;
            state_r  <= S_MI;
          end
        end
        S_MI: begin
          if (mul_done) begin
            integ_r  <= integ_nxt;
            op_a_r   <= MULA_W'(diff[ERR_W] ? -diff : diff);
            op_b_r   <= gd_r[GAIN_W-1] ? GAIN_W'(-gd_r) : GAIN_W'(gd_r);
            mul_go_r <= 1'b1;
            state_r  <= S_MD;
          end
        end
        S_MD: begin
          if (mul_done) begin
            op_a_r   <= mul_prod[MULA_W-1:0];
            op_b_r   <= DERIV_SCALE;
            mul_go_r <= 1'b1;
            state_r  <= S_MK;
          end
        end
        S_MK: begin
          if (mul_done) begin
            if (dt_r == 16'd0) begin
              d_r     <= '0;
              state_r <= S_SUM;
            end else begin
              div_go_r <= 1'b1;
              state_r  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            d_r     <= (gd_r[GAIN_W-1] ^ diff[ERR_W]) ? -64'(div_q) : 64'(div_q);
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sum_r      <= sum_c;
          last_err_r <= err_r;
          state_r    <= S_FIN;
        end
        S_FIN: begin
          // Hold the finished result until the output register is free.
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, err_r, ang_r, drv, pr, pl};
            out_zero_r  <= (dt_r == 16'd0);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_zero_r;

endmodule

// ===== rtl/tpdm_cordic.sv =====
// Iterative CORDIC in vectoring mode: one micro-rotation per clock.
// Depends on tpdm_pkg for the step count and the arctangent table.
`timescale 1ns / 1ps
module tpdm_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [15:0]                 accel_x,
  input  logic signed [15:0]                 accel_z,
  output logic                               done,
  output logic signed [tpdm_pkg::ANG_W-1:0]  angle
);
  import tpdm_pkg::*;

  logic signed [CX_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [CACC_W-1:0] acc_r, acc_nxt, rnd;
  logic [4:0]               i_r;
  logic                     busy_r, done_r, zero_r;

  always_comb begin
    if (y_r >= 0) begin
      x_nxt   = x_r + (y_r >>> i_r);
      y_nxt   = y_r - (x_r >>> i_r);
      acc_nxt = acc_r + atan_of(i_r);
    end else begin
      x_nxt   = x_r - (y_r >>> i_r);
      y_nxt   = y_r + (x_r >>> i_r);
      acc_nxt = acc_r - atan_of(i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
      zero_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r    <= '0;
        zero_r <= (accel_x == 16'sd0) && (accel_z == 16'sd0);
        busy_r <= 1'b1;
        // Fold the left half plane onto the right one with a quarter turn.
        if (accel_z < 0) begin
          if (accel_x >= 0) begin
            x_r   <= CX_W'(accel_x);
            y_r   <= -CX_W'(accel_z);
            acc_r <= CACC_W'(ANG_QUARTER * 256);
          end else begin
            x_r   <= -CX_W'(accel_x);
            y_r   <= CX_W'(accel_z);
            acc_r <= -CACC_W'(ANG_QUARTER * 256);
          end
        end else begin
          x_r   <= CX_W'(accel_z);
          y_r   <= CX_W'(accel_x);
          acc_r <= '0;
        end
      end else if (busy_r) begin
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        acc_r <= acc_nxt;
        i_r   <= i_r + 5'd1;
        if (i_r == 5'(NUM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rnd  = (acc_r + 25'sd128) >>> 8;
  assign done = done_r;

  always_comb begin
    if (zero_r)                    angle = '0;
    else if (rnd > ANG_HALF)       angle = 16'(ANG_HALF);
    else if (rnd < -ANG_HALF)      angle = -16'(ANG_HALF);
    else                           angle = rnd[15:0];
  end

endmodule

// ===== rtl/tpdm_mul.sv =====
// Bit-serial shift-add multiplier on magnitudes: one multiplier bit per clock.
// Depends on tpdm_pkg for operand and product widths.
`timescale 1ns / 1ps
module tpdm_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [tpdm_pkg::MULA_W-1:0]        op_a,
  input  logic [tpdm_pkg::GAIN_W-1:0]        op_b,
  output logic                               done,
  output logic [tpdm_pkg::PROD_W-1:0]        prod
);
  import tpdm_pkg::*;

  logic [PROD_W-1:0] a_r, acc_r;
  logic [GAIN_W-1:0] b_r;
  logic [4:0]        cnt_r;
  logic              busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= PROD_W'(op_a);
        b_r    <= op_b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) acc_r <= acc_r + a_r;
        a_r   <= a_r << 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(GAIN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/tpdm_div.sv =====
// Restoring divider, one quotient bit per clock, for the derivative rate term.
// Depends on tpdm_pkg for dividend and divisor widths.
`timescale 1ns / 1ps
module tpdm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [tpdm_pkg::DIVN_W-1:0]        dividend,
  input  logic [tpdm_pkg::DIVD_W-1:0]        divisor,
  output logic                               done,
  output logic [tpdm_pkg::DIVN_W-1:0]        quotient
);
  import tpdm_pkg::*;

  logic [DIVN_W-1:0] q_r;
  logic [DIVD_W-1:0] d_r;
  logic [DIVD_W:0]   rem_r, trial;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r, fits;

  assign trial = {rem_r[DIVD_W-1:0], q_r[DIVN_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? (trial - {1'b0, d_r}) : trial;
        q_r   <= {q_r[DIVN_W-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIVN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/tpdm_checker.sv =====
// Port-level checks for the tilt PID motor mixer, attached by bind.
// Depends only on the ports of tilt_pid_differential_motor_mix_core.
`timescale 1ns / 1ps
module tpdm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A sample transfer occupies the block, so the next cycle cannot take another.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:0] >= 11'd1000 && out_tdata[10:0] <= 11'd2000 &&
                   out_tdata[21:11] >= 11'd1000 && out_tdata[21:11] <= 11'd2000)
    else $error("motor pulse out of range");

  // Positive drive pushes the left motor at least as hard as the right one.
  a_mix_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[10:0] >= out_tdata[21:11])
    else $error("motor mix does not follow drive sign");

endmodule

bind tilt_pid_differential_motor_mix_core tpdm_checker u_tpdm_checker (.*);
